@@ hdl/sha256_stream_hasher_defines.svh @@
// Assertion macros for the SHA-256 stream hasher.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shs assertion failed");

// next-cycle implication, checked out of reset
`define SHS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shs assertion failed");

`endif

@@ hdl/shs_pkg.sv @@
// Package for the SHA-256 stream hasher: item types, command/status structs,
// round constants, initial hash values and the sigma functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] BSEL_IN    = 2'd0;
    localparam logic [1:0] BSEL_PAD80 = 2'd1;
    localparam logic [1:0] BSEL_ZERO  = 2'd2;
    localparam logic [1:0] BSEL_LEN   = 2'd3;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [5:0] FILL_LENPOS = 6'd56;
    localparam logic [5:0] RND_LAST    = 6'd63;
    localparam logic [2:0] IDX_LAST    = 3'd7;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic       wr_byte;
        logic [1:0] byte_sel;
        logic       latch_total;
        logic       load_v;
        logic       count_blk;
        logic       round;
        logic [5:0] rnd_idx;
        logic       add_h;
        logic       init_h;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_stat;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        sml_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        sml_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

@@ hdl/shs_datapath.sv @@
// Datapath of the SHA-256 stream hasher: byte gathering, schedule shift line,
// round registers, chaining words and length counters. Uses shs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shs_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire shs_pkg::t_cmd   i_cmd,
    input  wire logic [7:0]      i_byte,
    output shs_pkg::t_stat       o_stat,
    output shs_pkg::t_out_item   o_item
);
    import shs_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [23:0] r_word;
    logic [5:0]  r_fill;
    logic [63:0] r_bitlen;
    logic [63:0] r_total;

    logic [7:0]  byte_mux;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  len_base;

    assign len_base = {~r_fill[2:0], 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            BSEL_IN:    byte_mux = i_byte;
            BSEL_PAD80: byte_mux = PAD_BYTE;
            BSEL_ZERO:  byte_mux = 8'h00;
            default:    byte_mux = r_total[len_base +: 8];
        endcase
    end

    assign w_new = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_ROUND[i_cmd.rnd_idx] + r_w[0];
    assign t2 = big_s0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // control-like state: fill, length, chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_bitlen <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            if (i_cmd.wr_byte) r_fill <= r_fill + 6'd1;
            if (i_cmd.init_h) begin
                r_bitlen <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
            end else begin
                if (i_cmd.count_blk) r_bitlen <= r_bitlen + BLOCK_BITS;
                if (i_cmd.add_h)
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // payload: word gather, schedule, working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_total) r_total <= r_bitlen + {55'd0, r_fill, 3'b000};
        if (i_cmd.wr_byte) begin
            r_word <= {r_word[15:0], byte_mux};
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= {r_word, byte_mux};
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_cmd.load_v) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_stat.fill        = r_fill;
    assign o_item.digest_word = r_h[i_cmd.out_idx];
    assign o_item.word_index  = i_cmd.out_idx;
    assign o_item.last_word   = (i_cmd.out_idx == IDX_LAST);

endmodule
`default_nettype wire

@@ hdl/shs_ctrl.sv @@
// Controller of the SHA-256 stream hasher: sequences absorb, padding,
// 64 rounds, chaining update and digest output. Uses shs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_op,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire shs_pkg::t_stat  i_stat,
    output shs_pkg::t_cmd        o_cmd
);
    import shs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADDH  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_idx, n_idx;
    logic       r_first, n_first;
    logic       r_lenok, n_lenok;
    logic       r_final, n_final;
    logic       r_padding, n_padding;
    logic       lenok_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rnd     <= '0;
            r_idx     <= '0;
            r_first   <= 1'b0;
            r_lenok   <= 1'b0;
            r_final   <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rnd     <= n_rnd;
            r_idx     <= n_idx;
            r_first   <= n_first;
            r_lenok   <= n_lenok;
            r_final   <= n_final;
            r_padding <= n_padding;
        end
    end

    // length fits this block when the 0x80 byte lands before byte 56
    assign lenok_now = r_first ? (i_stat.fill < FILL_LENPOS) : r_lenok;

    always_comb begin
        n_state     = r_state;
        n_rnd       = r_rnd;
        n_idx       = r_idx;
        n_first     = r_first;
        n_lenok     = r_lenok;
        n_final     = r_final;
        n_padding   = r_padding;
        o_cmd       = '0;
        o_cmd.rnd_idx = r_rnd;
        o_cmd.out_idx = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_ABSORB) begin
                        o_cmd.wr_byte  = 1'b1;
                        o_cmd.byte_sel = BSEL_IN;
                        if (i_stat.fill == FILL_LAST) begin
                            o_cmd.load_v    = 1'b1;
                            o_cmd.count_blk = 1'b1;
                            n_rnd     = '0;
                            n_final   = 1'b0;
                            n_padding = 1'b0;
                            n_state   = ST_ROUND;
                        end
                    end else begin
                        o_cmd.latch_total = 1'b1;
                        n_first   = 1'b1;
                        n_lenok   = 1'b0;
                        n_padding = 1'b1;
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.wr_byte = 1'b1;
                if (r_first)
                    o_cmd.byte_sel = BSEL_PAD80;
                else if (r_lenok && (i_stat.fill >= FILL_LENPOS))
                    o_cmd.byte_sel = BSEL_LEN;
                else
                    o_cmd.byte_sel = BSEL_ZERO;
                n_first = 1'b0;
                n_lenok = lenok_now;
                if (i_stat.fill == FILL_LAST) begin
                    o_cmd.load_v = 1'b1;
                    n_rnd   = '0;
                    n_final = lenok_now;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == RND_LAST) n_state = ST_ADDH;
            end
            ST_ADDH: begin
                o_cmd.add_h = 1'b1;
                if (r_final) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else if (r_padding) begin
                    n_lenok = 1'b1;
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == IDX_LAST) begin
                        o_cmd.init_h = 1'b1;
                        n_final   = 1'b0;
                        n_padding = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on shs_pkg, shs_ctrl, shs_datapath and the defines header.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+------------------------------
//  in      | into      | i_in_valid / o_in_ready       | i_in_item  (op, byte_value)
//  out     | out of    | o_out_valid / i_out_ready     | o_out_item (digest_word,
//          |           |                               |   word_index, last_word)
//
// Each absorb item writes one byte; the 64th byte of a block then starts the
// 64-round loop and then the chaining add, both run by the single shared round
// unit. A finish item walks the padding one byte a cycle up to the block end,
// runs one or two compressions, then offers the eight digest words, one per
// cycle while i_out_ready is high.
// Input is held off (o_in_ready low) during rounds, padding and output; a
// stalled output word simply holds. Reset is synchronous and restores the
// initial hash values with zero fill and zero length.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire shs_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output shs_pkg::t_out_item       o_out_item
);
    import shs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: owns state, round and word counters
    shs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_item.op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: gather, schedule, rounds, chaining words
    shs_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (i_in_item.byte_value),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

    // no input item taken while the digest is being offered
    `SHS_ASSERT_IMP(a_no_in_during_out, o_out_valid, !o_in_ready)
    // a full block always starts compression, blocking input next cycle
    `SHS_ASSERT_NXT(a_block_starts_rounds,
        i_in_valid && o_in_ready && (i_in_item.op == OP_ABSORB) && (stat.fill == FILL_LAST),
        !o_in_ready)
    // taking the last digest word returns the block to idle
    `SHS_ASSERT_NXT(a_last_word_to_idle,
        o_out_valid && i_out_ready && o_out_item.last_word, o_in_ready && !o_out_valid)

endmodule
`default_nettype wire
